FILE: sv/mcdc_pkg.sv
// Package for the multi-channel debounce counter.
// Holds channel counts, action and register codes, and lane/result types.
// No dependencies.
package mcdc_pkg;

  localparam int unsigned CHANNELS   = 6;   // channels actually processed, 1..MAX_CH
  localparam int unsigned MAX_CH     = 6;   // width of the level fields
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned DEB_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

  // Bits of the level fields that belong to processed channels
  localparam logic [MAX_CH-1:0] CHAN_MASK = MAX_CH'((64'd1 << CHANNELS) - 64'd1);

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_RESYNC = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TIME = 8'd0,
    CFG_INVERT_ACTIVE = 8'd1
  } cfg_idx_e;

  // What one lane reports after an item
  typedef struct packed {
    logic               raw;
    logic               stable;
    logic [COUNT_W-1:0] count;
  } lane_res_t;

  typedef struct packed {
    logic [MAX_CH-1:0]              raw;
    logic [MAX_CH-1:0]              stable;
    logic [MAX_CH-1:0]              active;
    logic [MAX_CH-1:0][COUNT_W-1:0] count;
  } result_t;

endpackage

FILE: sv/mcdc_lane.sv
// One debounce lane: raw tracking, change stamp, stable level and change count.
// Depends on mcdc_pkg. Reports its post-item state combinationally.
module mcdc_lane
  import mcdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [1:0]         action_i,
  input  logic [TIME_W-1:0]  time_ms_i,
  input  logic               raw_bit_i,
  input  logic [DEB_W-1:0]   debounce_time_i,
  output lane_res_t          lane_res_o
);

  logic               held_raw_q, held_raw_d;
  logic               raw_seen_q, raw_seen_d;
  logic               stable_q, stable_d;
  logic [TIME_W-1:0]  stamp_q, stamp_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic [TIME_W-1:0]  stamp_smp;
  logic [TIME_W-1:0]  held_for;
  logic               settled;

  // Sample path: stamp moves on a raw edge, then elapsed time is checked
  assign stamp_smp = (raw_bit_i != held_raw_q) ? time_ms_i : stamp_q;
  assign held_for  = time_ms_i - stamp_smp;
  assign settled   = (held_for >= {{(TIME_W-DEB_W){1'b0}}, debounce_time_i})
                     && (stable_q != raw_bit_i);

  always_comb begin
    held_raw_d = held_raw_q;
    raw_seen_d = raw_seen_q;
    stable_d   = stable_q;
    stamp_d    = stamp_q;
    count_d    = count_q;
    if (accept_i) begin
      case (action_i)
        ACT_SAMPLE: begin
          raw_seen_d = raw_bit_i;
          held_raw_d = raw_bit_i;
          stamp_d    = stamp_smp;
          if (settled) begin
            stable_d = raw_bit_i;
            count_d  = count_q + COUNT_W'(1);
          end
        end
        ACT_CLEAR: begin
          count_d = '0;
        end
        ACT_RESYNC: begin
          raw_seen_d = raw_bit_i;
          held_raw_d = raw_bit_i;
          stable_d   = raw_bit_i;
          stamp_d    = time_ms_i;
        end
        default: begin
          // unused code: state holds
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_raw_q <= 1'b0;
      raw_seen_q <= 1'b0;
      stable_q   <= 1'b0;
      stamp_q    <= '0;
      count_q    <= '0;
    end else begin
      held_raw_q <= held_raw_d;
      raw_seen_q <= raw_seen_d;
      stable_q   <= stable_d;
      stamp_q    <= stamp_d;
      count_q    <= count_d;
    end
  end

  assign lane_res_o.raw    = raw_seen_d;
  assign lane_res_o.stable = stable_d;
  assign lane_res_o.count  = count_d;

endmodule

FILE: sv/mcdc_merge.sv
// Merge stage: packs the lane reports into one result item and holds it
// in an output register backed by a skid register. Depends on mcdc_pkg.
module mcdc_merge
  import mcdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  lane_res_t lane_res_i [MAX_CH],
  input  logic      invert_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output logic      in_stall_o,
  output result_t   res_o
);

  result_t merged;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    take;

  always_comb begin
    merged = '0;
    for (int c = 0; c < MAX_CH; c++) begin
      merged.raw[c]    = lane_res_i[c].raw;
      merged.stable[c] = lane_res_i[c].stable;
      merged.count[c]  = lane_res_i[c].count;
    end
    merged.raw    = merged.raw & CHAN_MASK;
    merged.stable = merged.stable & CHAN_MASK;
    merged.active = (merged.stable ^ {MAX_CH{invert_i}}) & CHAN_MASK;
  end

  assign take = out_valid_q && !out_stall_i;

  // An accept only happens with the skid empty (stall is the skid flag)
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (accept_i) begin
      if (!out_valid_q || take) begin
        out_d       = merged;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = merged;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign in_stall_o  = skid_valid_q;
  assign res_o       = out_q;

endmodule

FILE: sv/multi_channel_debounce_counter_top.sv
// Six-channel time-based switch debouncer with per-channel change counters.
// Input items carry an action, a millisecond time and six raw levels; every
// accepted item yields one result item with raw, stable and active levels
// and the six change counts as they stand after that item.
// Channels: input (in_valid_i / in_stall_o), output (out_valid_o /
// out_stall_i), config writes (cfg_valid_i / cfg_ready_o, always ready):
// index 0 debounce time in ms, index 1 active-level invert in data bit 0.
// An accepted result is registered in the output register, or in the skid
// register if the output is stalled. Throughput: one item per cycle while
// in_stall_o is low; each lane subtracts, compares and increments at accept.
// When the receiver stalls, one more item goes into a skid register, after
// which in_stall_o rises until the output drains.
// Reset clears all channel state, counts and stamps to zero, debounce time
// to 20 ms and invert to off; issue a resync item first after reset.
// Depends on mcdc_pkg, mcdc_lane, mcdc_merge.
module multi_channel_debounce_counter_top
  import mcdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic [TIME_W-1:0]     time_ms_i,
  input  logic [MAX_CH-1:0]     raw_levels_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MAX_CH-1:0]     raw_out_o,
  output logic [MAX_CH-1:0]     stable_out_o,
  output logic [MAX_CH-1:0]     active_out_o,
  output logic [COUNT_W-1:0]    count_ch0_o,
  output logic [COUNT_W-1:0]    count_ch1_o,
  output logic [COUNT_W-1:0]    count_ch2_o,
  output logic [COUNT_W-1:0]    count_ch3_o,
  output logic [COUNT_W-1:0]    count_ch4_o,
  output logic [COUNT_W-1:0]    count_ch5_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [DEB_W-1:0] debounce_time_q, debounce_time_d;
  logic             invert_active_q, invert_active_d;
  logic             accept;
  lane_res_t        lane_res [MAX_CH];
  result_t          res;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    debounce_time_d = debounce_time_q;
    invert_active_d = invert_active_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEBOUNCE_TIME: debounce_time_d = cfg_data_i[DEB_W-1:0];
        CFG_INVERT_ACTIVE: invert_active_d = cfg_data_i[0];
        default: begin
          // unknown register: ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_time_q <= DEBOUNCE_RESET;
      invert_active_q <= 1'b0;
    end else begin
      debounce_time_q <= debounce_time_d;
      invert_active_q <= invert_active_d;
    end
  end

  for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_used
      mcdc_lane u_lane (
        .clk_i           (clk_i),
        .rst_ni          (rst_ni),
        .accept_i        (accept),
        .action_i        (action_i),
        .time_ms_i       (time_ms_i),
        .raw_bit_i       (raw_levels_i[c]),
        .debounce_time_i (debounce_time_q),
        .lane_res_o      (lane_res[c])
      );
    end else begin : g_unused
      assign lane_res[c] = '0;
    end
  end

  mcdc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .lane_res_i  (lane_res),
    .invert_i    (invert_active_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .in_stall_o  (in_stall_o),
    .res_o       (res)
  );

  assign raw_out_o    = res.raw;
  assign stable_out_o = res.stable;
  assign active_out_o = res.active;
  assign count_ch0_o  = res.count[0];
  assign count_ch1_o  = res.count[1];
  assign count_ch2_o  = res.count[2];
  assign count_ch3_o  = res.count[3];
  assign count_ch4_o  = res.count[4];
  assign count_ch5_o  = res.count[5];

endmodule

FILE: sv/mcdc_checker.sv
// Port-level checks for multi_channel_debounce_counter_top, bound to it below.
// Depends on mcdc_pkg.
module mcdc_checker
  import mcdc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [MAX_CH-1:0]     stable_out_o,
  input logic [MAX_CH-1:0]     active_out_o,
  input logic [COUNT_W-1:0]    count_ch0_o
);

  // a stalled item stays on the port
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_ch0_o)
      && $stable(stable_out_o) && $stable(active_out_o))
    else $error("stalled output item changed");

  // after every accepted item the output is valid next cycle (output or skid register)
  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no output");

  // input only backs up when the output is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // active is stable with one common invert over all processed channels
  a_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((active_out_o ^ stable_out_o) == '0)
      || ((active_out_o ^ stable_out_o) == CHAN_MASK))
    else $error("active levels inconsistent with stable levels");

endmodule

bind multi_channel_debounce_counter_top mcdc_checker u_mcdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .stable_out_o (stable_out_o),
  .active_out_o (active_out_o),
  .count_ch0_o  (count_ch0_o)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for multi_channel_debounce_counter_top: directed and random
// items, with prediction done in-line. Needs mcdc_pkg and the RTL of the block.
module tb;
  import mcdc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;  // no action: result shows current state
  localparam int IDLE_LIMIT = 2000;          // cycles with no handshake before giving up

  typedef struct packed {
    logic [1:0]        act;
    logic [TIME_W-1:0] ms;
    logic [MAX_CH-1:0] lv;
  } pin_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            action_i = ACT_SAMPLE;
  logic [TIME_W-1:0]     time_ms_i = '0;
  logic [MAX_CH-1:0]     raw_levels_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [MAX_CH-1:0]     raw_out_o, stable_out_o, active_out_o;
  logic [COUNT_W-1:0]    count_ch0_o, count_ch1_o, count_ch2_o;
  logic [COUNT_W-1:0]    count_ch3_o, count_ch4_o, count_ch5_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  multi_channel_debounce_counter_top u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state, one bit or word per channel
  logic [MAX_CH-1:0]  seen_lv = '0;
  logic [MAX_CH-1:0]  held_lv = '0;
  logic [MAX_CH-1:0]  stable_lv = '0;
  logic [TIME_W-1:0]  changed_at [MAX_CH];
  logic [COUNT_W-1:0] flips [MAX_CH];
  logic [DEB_W-1:0]   hold_ms = DEBOUNCE_RESET;
  logic               invert_on = 1'b0;

  pin_item_t pending_items [$];
  result_t   expected_results [$];
  pin_item_t cur_item;
  result_t   want_res, seen_res;

  logic [TIME_W-1:0] gen_ms;
  logic [MAX_CH-1:0] gen_lv = '0;

  bit in_taken = 0, out_taken = 0, cfg_taken = 0, hold_done = 0;
  int n_in = 0, n_out = 0, n_err = 0, n_debounced = 0, idle_cycles = 0;
  int gap_left = 0, send_calm = 0, hold_left = 0, stall_left = 0, recv_calm = 0;
  int unsigned pick;
  int unsigned stall_pick;

  initial begin
    for (int ch = 0; ch < MAX_CH; ch++) begin
      changed_at[ch] = '0;
      flips[ch] = '0;
    end
  end

  function automatic result_t debounce_predict(input logic [1:0] act,
                                               input logic [TIME_W-1:0] now,
                                               input logic [MAX_CH-1:0] lv);
    result_t r;
    logic [TIME_W-1:0] held_for;
    r = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      case (act)
        ACT_SAMPLE: begin
          seen_lv[ch] = lv[ch];
          if (lv[ch] != held_lv[ch]) begin
            held_lv[ch] = lv[ch];
            changed_at[ch] = now;
          end
          held_for = now - changed_at[ch];  // modulo 2^32
          if (held_for >= TIME_W'(hold_ms) && stable_lv[ch] != lv[ch]) begin
            stable_lv[ch] = lv[ch];
            flips[ch] = flips[ch] + COUNT_W'(1);
            n_debounced++;
          end
        end
        ACT_CLEAR: flips[ch] = '0;
        ACT_RESYNC: begin
          seen_lv[ch] = lv[ch];
          held_lv[ch] = lv[ch];
          stable_lv[ch] = lv[ch];
          changed_at[ch] = now;
        end
        default: ;
      endcase
      r.raw[ch] = seen_lv[ch];
      r.stable[ch] = stable_lv[ch];
      r.active[ch] = stable_lv[ch] ^ invert_on;
      r.count[ch] = flips[ch];
    end
    return r;
  endfunction

  // Monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      out_taken = out_valid_o && !out_stall_i;
      cfg_taken = cfg_valid_i && cfg_ready_o;
      if (cfg_taken) begin
        case (cfg_index_i)
          CFG_DEBOUNCE_TIME: hold_ms = cfg_data_i[DEB_W-1:0];
          CFG_INVERT_ACTIVE: invert_on = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_taken) begin
        expected_results.push_back(debounce_predict(action_i, time_ms_i, raw_levels_i));
        n_in++;
      end
      if (out_taken) begin
        n_out++;
        seen_res.raw = raw_out_o;
        seen_res.stable = stable_out_o;
        seen_res.active = active_out_o;
        seen_res.count[0] = count_ch0_o;
        seen_res.count[1] = count_ch1_o;
        seen_res.count[2] = count_ch2_o;
        seen_res.count[3] = count_ch3_o;
        seen_res.count[4] = count_ch4_o;
        seen_res.count[5] = count_ch5_o;
        if (expected_results.size() == 0) begin
          $error("result item with no item pending");
          n_err++;
        end else begin
          want_res = expected_results.pop_front();
          if (seen_res.raw !== want_res.raw) begin
            $error("raw_out: expected %h, got %h", want_res.raw, seen_res.raw);
            n_err++;
          end
          if (seen_res.stable !== want_res.stable) begin
            $error("stable_out: expected %h, got %h", want_res.stable, seen_res.stable);
            n_err++;
          end
          if (seen_res.active !== want_res.active) begin
            $error("active_out: expected %h, got %h", want_res.active, seen_res.active);
            n_err++;
          end
          for (int ch = 0; ch < MAX_CH; ch++) begin
            if (seen_res.count[ch] !== want_res.count[ch]) begin
              $error("count_ch%0d: expected %0d, got %0d", ch, want_res.count[ch],
                     seen_res.count[ch]);
              n_err++;
            end
          end
        end
      end
      if (in_taken || out_taken || cfg_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sender: holds each item until taken, random gaps between items
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_valid_i <= 1'b1;
        action_i <= cur_item.act;
        time_ms_i <= cur_item.ms;
        raw_levels_i <= cur_item.lv;
        pick = $urandom_range(0, 99);
        if (send_calm > 0) send_calm--;
        else if (pick < 55) gap_left = 0;
        else if (pick < 85) gap_left = $urandom_range(1, 3);
        else if (pick < 92) gap_left = $urandom_range(10, 30);
        else send_calm = $urandom_range(10, 40);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && n_in >= 100) begin
      hold_done = 1;
      hold_left = 80;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (recv_calm > 0) begin
      recv_calm--;
      out_stall_i <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall_i <= 1'b0;
      end else if (stall_pick < 70) begin
        recv_calm = $urandom_range(10, 40);
        out_stall_i <= 1'b0;
      end else if (stall_pick < 95) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        stall_left = $urandom_range(8, 30);
        out_stall_i <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [1:0] act, input logic [TIME_W-1:0] ms,
                           input logic [MAX_CH-1:0] lv);
    pending_items.push_back('{act: act, ms: ms, lv: lv});
  endtask

  // Resync, then mostly samples with bouncing levels and time steps scaled to the hold
  task automatic queue_random_run(input int n, input int unsigned hold);
    int unsigned r;
    gen_lv = MAX_CH'($urandom);
    push_item(ACT_RESYNC, gen_ms, gen_lv);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_item(ACT_CLEAR, $urandom, MAX_CH'($urandom));
      end else if (r < 8) begin
        gen_ms += $urandom_range(0, hold + 2);
        gen_lv = MAX_CH'($urandom);
        push_item(ACT_RESYNC, gen_ms, gen_lv);
      end else if (r < 10) begin
        push_item(ACT_UNUSED, $urandom, MAX_CH'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) gen_ms += $urandom_range(0, hold / 4 + 1);
        else if (r < 85) gen_ms += $urandom_range(hold / 2, hold + hold / 2 + 2);
        else if (r < 97) gen_ms += $urandom_range(0, 3);
        else gen_ms = $urandom;  // time jumps, possibly backwards
        r = $urandom_range(0, 99);
        if (r < 30) gen_lv ^= MAX_CH'(1) << $urandom_range(0, CHANNELS - 1);
        else if (r < 40) gen_lv = MAX_CH'($urandom);
        push_item(ACT_SAMPLE, gen_ms, gen_lv);
      end
    end
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned hold;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: hold 20 ms, no invert
    push_item(ACT_SAMPLE, 32'd30, 6'h3F);          // sample before any resync
    push_item(ACT_RESYNC, 32'd0, 6'h00);
    push_item(ACT_SAMPLE, 32'd5, 6'h3F);
    push_item(ACT_SAMPLE, 32'd24, 6'h3F);          // one ms short
    push_item(ACT_SAMPLE, 32'd25, 6'h3F);          // exactly the hold time
    push_item(ACT_SAMPLE, 32'd30, 6'h15);          // bounce
    push_item(ACT_SAMPLE, 32'd32, 6'h3F);
    push_item(ACT_SAMPLE, 32'd34, 6'h15);
    push_item(ACT_SAMPLE, 32'd54, 6'h15);
    push_item(ACT_CLEAR, 32'hFFFF_FFFF, 6'h3F);
    push_item(ACT_UNUSED, 32'd123, 6'h2A);
    push_item(ACT_RESYNC, 32'hFFFF_FFF0, 6'h2A);
    push_item(ACT_SAMPLE, 32'hFFFF_FFF8, 6'h15);
    push_item(ACT_SAMPLE, 32'h0000_000B, 6'h15);   // across the wrap, 19 ms
    push_item(ACT_SAMPLE, 32'h0000_000C, 6'h15);   // 20 ms
    push_item(ACT_SAMPLE, 32'hFFFF_FFFF, 6'h00);   // time goes backwards
    push_item(ACT_SAMPLE, 32'h0000_0013, 6'h00);
    gen_ms = $urandom;
    queue_random_run(150, DEBOUNCE_RESET);
    settle();

    // Zero hold: a new level is stable in the same item
    write_reg(CFG_DEBOUNCE_TIME, 16'd0);
    write_reg(CFG_INVERT_ACTIVE, {15'($urandom), 1'b1});
    push_item(ACT_SAMPLE, 32'h5555_AAAA, 6'h3F);
    push_item(ACT_SAMPLE, 32'h5555_AAAA, 6'h00);
    push_item(ACT_SAMPLE, 32'hAAAA_5555, 6'h2A);
    queue_random_run(150, 0);
    settle();

    write_reg(CFG_DEBOUNCE_TIME, 16'hFFFF);
    write_reg(CFG_INVERT_ACTIVE, {15'($urandom), 1'b0});
    gen_ms = 32'hFFFE_0000;
    queue_random_run(150, 65535);
    settle();

    hold = $urandom_range(1, 64);
    write_reg(CFG_DEBOUNCE_TIME, DEB_W'(hold));
    write_reg(CFG_INVERT_ACTIVE, CFG_DATA_W'($urandom));
    queue_random_run(150, hold);
    settle();

    hold = $urandom_range(0, 65535);
    write_reg(CFG_INVERT_ACTIVE, CFG_DATA_W'($urandom));
    write_reg(CFG_DEBOUNCE_TIME, DEB_W'(hold));
    queue_random_run(150, hold);
    settle();

    $display("%0d items in, %0d results checked over five register settings", n_in, n_out);
    $display("%0d debounced level changes predicted, %0d mismatches", n_debounced, n_err);
    if (n_err == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
